### rtl/material_cell_shader_top_macros.svh
// Assertion macros shared by the checker of the material cell shader.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef MATERIAL_CELL_SHADER_TOP_MACROS_SVH
`define MATERIAL_CELL_SHADER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mcs_pkg.sv
// Package of the material cell shader: item types, register codes and constants.
// Depends on nothing; the top level, the palette and the checker import it.
package mcs_pkg;

	localparam int PALETTE_ENTRIES = 16;
	localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam int WORD_W = 26;
	localparam int APB_AW = 3;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef enum logic {
		REG_HEAT_OVERLAY = 1'b0,
		REG_EMPTY_CODE   = 1'b1
	} mcs_reg_t;

	typedef struct packed {
		logic              kind;
		logic [3:0]        cell_material;
		logic [7:0]        cell_shade;
		logic signed [7:0] cell_temperature;
		logic [3:0]        above_material;
		logic              above_present;
		logic [3:0]        left_material;
		logic              left_present;
		logic [3:0]        right_material;
		logic              right_present;
		logic [25:0]       palette_word;
	} mcs_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} mcs_rgb_t;

	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr;
		logic [WORD_W-1:0] data;
	} mcs_pal_wr_t;

	// Q10 factors (1024 is unity).
	localparam logic [10:0] Q_ONE        = 11'd1024;
	localparam logic [10:0] LIQ_BASE_LOW = 11'd876;   // 0.98 less the shade offset of 128
	localparam logic [10:0] LIQ_SURFACE  = 11'd164;
	localparam logic [10:0] LIQ_EDGE     = 11'd41;
	localparam logic [10:0] STR_MIN      = 11'd205;
	localparam logic [10:0] STR_MAX      = 11'd870;

	// Reciprocals in Q16: 1024/90 and 1024/100, rounded up; exact for magnitudes to 128.
	localparam logic [19:0] STR_RECIP  = 20'd745655;
	localparam logic [19:0] RAMP_RECIP = 20'd671089;

	localparam mcs_rgb_t HOT_LO  = '{red: 8'd255, green: 8'd120, blue: 8'd20};
	localparam mcs_rgb_t HOT_HI  = '{red: 8'd255, green: 8'd245, blue: 8'd210};
	localparam mcs_rgb_t COLD_LO = '{red: 8'd40,  green: 8'd120, blue: 8'd255};
	localparam mcs_rgb_t COLD_HI = '{red: 8'd180, green: 8'd240, blue: 8'd255};

endpackage

### rtl/material_cell_shader_top.sv
// Top level of the material cell shader: request and colour channels, APB registers.
// Depends on mcs_pkg and instantiates the palette memory mcs_palette.
//
// Use: each request item either writes a palette entry (kind set) or asks for the
// colour of one grid cell (kind clear). Palette writes take effect at the edge where
// the item is accepted and produce no response. Each cell item produces exactly one
// colour item on the response channel, in request order.
// Pipeline: a cell item accepted at one edge, where the palette read starts, shows its
// colour on rsp once the shading multiply, the ramp blend and the final blend have each
// been registered (stage 2, stage 3 and the output register) when nothing stalls.
// Throughput: one item per clock cycle while rsp_ready stays high, set by the single palette
// read port; each pipeline stage holds one item and passes it on every cycle the stage
// after it moves. Stalls: when rsp_ready is low the response holds, and new items are still
// taken as long as an empty stage remains in the pipeline, up to four cell items in flight.
// Reset: arst_n clears the pipeline, both registers and all palette valid marks, so every
// material reads as unknown (black) until its entry is written. Registers: heat_overlay_on
// at byte address 0, empty_code at 4; the user must write them only while the block is
// idle (not enforced by the block); pready is always high, reads return the register value.
module material_cell_shader_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  mcs_pkg::mcs_req_t          req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output mcs_pkg::mcs_rgb_t          rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mcs_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import mcs_pkg::*;

	// Linear blend of two channels with a Q10 weight of at most one; never leaves 0..255.
	function automatic logic [7:0] mix_chan(logic [7:0] a, logic [7:0] b, logic [10:0] t);
		logic signed [8:0]  diff;
		logic signed [20:0] prod;
		logic signed [20:0] acc;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		prod = diff * $signed({1'b0, t});
		acc  = $signed({3'b000, a, 10'b0}) + prod;
		return acc[17:10];
	endfunction

	function automatic mcs_rgb_t mix_rgb(mcs_rgb_t a, mcs_rgb_t b, logic [10:0] t);
		mcs_rgb_t o;
		o.red   = mix_chan(a.red, b.red, t);
		o.green = mix_chan(a.green, b.green, t);
		o.blue  = mix_chan(a.blue, b.blue, t);
		return o;
	endfunction

	// Channel times Q10 factor, saturated at 255.
	function automatic logic [7:0] scale_chan(logic [7:0] c, logic [10:0] f);
		logic [18:0] p;
		p = c * f;
		return p[18] ? 8'd255 : p[17:10];
	endfunction

	// Configuration registers.
	logic       heat_on_q;
	logic [3:0] empty_code_q;
	mcs_reg_t   reg_sel;

	assign reg_sel = mcs_reg_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heat_on_q    <= 1'b0;
			empty_code_q <= 4'd0;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_HEAT_OVERLAY: heat_on_q    <= pwdata[0];
				REG_EMPTY_CODE:   empty_code_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_HEAT_OVERLAY: prdata = {31'd0, heat_on_q};
			REG_EMPTY_CODE:   prdata = {28'd0, empty_code_q};
			default:          prdata = '0;
		endcase
	end

	// Pipeline occupancy and flow. A stage moves when the one after it is empty or moving.
	logic v_s1, v_s2, v_s3, rsp_valid_q;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3    = !rsp_valid_q || rsp_ready;
	assign adv_s2    = !v_s3 || adv_s3;
	assign adv_s1    = !v_s2 || adv_s2;
	assign req_ready = !v_s1 || adv_s1;
	assign rsp_valid = rsp_valid_q;

	logic req_fire, req_pixel, req_in_range;

	assign req_fire     = req_valid && req_ready;
	assign req_pixel    = req.kind == KIND_PIXEL;
	assign req_in_range = 32'(req.cell_material) < 32'(PALETTE_ENTRIES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_ready) begin
				v_s1 <= req_valid && req_pixel;
			end
			if (adv_s1) begin
				v_s2 <= v_s1;
			end
			if (adv_s2) begin
				v_s3 <= v_s2;
			end
			if (adv_s3) begin
				rsp_valid_q <= v_s3;
			end
		end
	end

	// Palette memory: writes land at acceptance, cell items read it on the same edge.
	mcs_pal_wr_t       pal_wr;
	logic [WORD_W-1:0] pal_data;
	logic              pal_written;

	assign pal_wr.en   = req_fire && !req_pixel && req_in_range;
	assign pal_wr.addr = PAL_AW'(req.cell_material);
	assign pal_wr.data = req.palette_word;

	mcs_palette u_palette (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (pal_wr),
		.rd_en        (req_fire && req_pixel),
		.rd_addr      (PAL_AW'(req.cell_material)),
		.rd_data_q    (pal_data),
		.rd_written_q (pal_written)
	);

	// Stage 1 holds the cell fields while the palette word comes out of the memory.
	mcs_req_t req_s1;
	logic     in_range_s1;

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1      <= req;
			in_range_s1 <= req_in_range;
		end
	end

	logic [WORD_W-1:0] entry;
	logic              black, surface, edge_empty;
	logic [10:0]       factor;
	mcs_rgb_t          base_col;
	logic [7:0]        mag;
	logic [27:0]       str_prod, ramp_prod;
	logic [11:0]       str_raw, ramp_raw;
	logic [9:0]        strength;
	logic [10:0]       ramp_t;

	always_comb begin
		entry = pal_written ? pal_data : '0;
		black = (req_s1.cell_material == empty_code_q) || !in_range_s1 || !entry[25];

		// Liquids get a calm factor, lifted at an open surface and beside an empty cell.
		surface    = !req_s1.above_present || (req_s1.above_material != req_s1.cell_material);
		edge_empty = (req_s1.left_present && (req_s1.left_material == empty_code_q)) ||
			(req_s1.right_present && (req_s1.right_material == empty_code_q));
		if (entry[24]) begin
			factor = LIQ_BASE_LOW + {3'd0, req_s1.cell_shade} +
				(surface ? LIQ_SURFACE : 11'd0) + (edge_empty ? LIQ_EDGE : 11'd0);
		end else begin
			factor = {req_s1.cell_shade, 3'b000};
		end

		if (black) begin
			base_col = '0;
		end else begin
			base_col.red   = scale_chan(entry[7:0], factor);
			base_col.green = scale_chan(entry[15:8], factor);
			base_col.blue  = scale_chan(entry[23:16], factor);
		end

		// Temperature magnitude divided by 90 and by 100 through Q16 reciprocals.
		mag       = req_s1.cell_temperature[7] ? 8'(-req_s1.cell_temperature)
			: 8'(req_s1.cell_temperature);
		str_prod  = mag * STR_RECIP;
		ramp_prod = mag * RAMP_RECIP;
		str_raw   = str_prod[27:16];
		ramp_raw  = ramp_prod[27:16];

		if (str_raw < 12'(STR_MIN)) begin
			strength = 10'(STR_MIN);
		end else if (str_raw > 12'(STR_MAX)) begin
			strength = 10'(STR_MAX);
		end else begin
			strength = str_raw[9:0];
		end
		ramp_t = (ramp_raw > 12'(Q_ONE)) ? Q_ONE : ramp_raw[10:0];
	end

	// Stage 2: shaded base colour and blend weights.
	mcs_rgb_t    base_s2;
	logic        overlay_s2, hot_s2;
	logic [9:0]  strength_s2;
	logic [10:0] ramp_t_s2;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			base_s2     <= base_col;
			overlay_s2  <= heat_on_q && (req_s1.cell_temperature != 8'sd0) && !black;
			hot_s2      <= !req_s1.cell_temperature[7];
			strength_s2 <= strength;
			ramp_t_s2   <= ramp_t;
		end
	end

	mcs_rgb_t ramp_col;

	always_comb begin
		if (hot_s2) begin
			ramp_col = mix_rgb(HOT_LO, HOT_HI, ramp_t_s2);
		end else begin
			ramp_col = mix_rgb(COLD_LO, COLD_HI, ramp_t_s2);
		end
	end

	// Stage 3: ramp colour ready, final blend toward it.
	mcs_rgb_t   base_s3, ramp_s3;
	logic       overlay_s3;
	logic [9:0] strength_s3;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			base_s3     <= base_s2;
			ramp_s3     <= ramp_col;
			overlay_s3  <= overlay_s2;
			strength_s3 <= strength_s2;
		end
	end

	mcs_rgb_t final_col;

	assign final_col = overlay_s3 ? mix_rgb(base_s3, ramp_s3, {1'b0, strength_s3}) : base_s3;

	// Output register.
	mcs_rgb_t rsp_q;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			rsp_q <= final_col;
		end
	end

	assign rsp = rsp_q;

endmodule

### rtl/mcs_palette.sv
// Palette memory of the material cell shader: one write port, one registered read port.
// Depends on mcs_pkg for the depth, word width and write command type.
module mcs_palette (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mcs_pkg::mcs_pal_wr_t       wr,
	input  logic                       rd_en,
	input  logic [mcs_pkg::PAL_AW-1:0] rd_addr,
	output logic [mcs_pkg::WORD_W-1:0] rd_data_q,
	output logic                       rd_written_q
);
	import mcs_pkg::*;

	logic [WORD_W-1:0]          mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] written_q;

	// A read and a write never fall in the same cycle, since each comes from its own item.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Entries never written keep a clear written mark, so the top level reads them as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

endmodule

### rtl/mcs_checker.sv
// Port-level checker of the material cell shader and its bind to the top level.
// Depends on mcs_pkg and the assertion macros in material_cell_shader_top_macros.svh.
`include "material_cell_shader_top_macros.svh"

module mcs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input mcs_pkg::mcs_req_t          req,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input mcs_pkg::mcs_rgb_t          rsp,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [mcs_pkg::APB_AW-1:0] paddr,
	input logic [31:0]                pwdata,
	input logic [31:0]                prdata,
	input logic                       pready
);
	import mcs_pkg::*;

	// A stalled colour item keeps its value.
	`MCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp changed while stalled")

	// With the receiver taking everything, a cell item comes out once it has passed stages 1 to 3 and the output register.
	`MCS_ASSERT_NEXT(a_cell_latency, (req_valid && req_ready && (req.kind == KIND_PIXEL)) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready, rsp_valid, "cell item did not arrive in time")

	// Register reads carry no bits beyond the widest register.
	`MCS_ASSERT_NOW(a_prdata_width, psel && !pwrite && pready, prdata[31:4] == 28'd0, "prdata has stray upper bits")

endmodule

bind material_cell_shader_top mcs_checker u_mcs_checker (.*);
